/* design/mhdcv_pkg.sv */
// ----------------------------------------------------------------------------
// MHD state conversion package
// Shared word format, fixed-point helpers, codes and the pipeline item types.
// ----------------------------------------------------------------------------
package mhdcv_pkg;

  // Word format: signed two's complement with a binary point.
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int CFG_IDX_BITS = 2;

  typedef logic signed [WORD_BITS-1:0]   word_t;
  typedef logic        [WORD_BITS-1:0]   uword_t;
  typedef logic        [WORD_BITS-2:0]   coef_t;
  typedef logic signed [2*WORD_BITS-1:0] prod_t;

  localparam word_t  WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t  WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam uword_t SIGN_MAG = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Register reset values for an adiabatic index of five thirds.
  localparam coef_t GAMMA_M1_RST = coef_t'(((64'd4 << FRAC_BITS) + 64'd3) / 64'd6);
  localparam coef_t INV_GAMMA_M1_RST = coef_t'(64'd3 << (FRAC_BITS - 1));

  typedef enum logic {
    OP_CONS_TO_PRIM = 1'b0,
    OP_PRIM_TO_CONS = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NEG_PRESSURE = 2'd1,
    ST_ZERO_DENSITY = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_GAMMA_M1     = 2'd0,
    CFG_INV_GAMMA_M1 = 2'd1
  } cfg_index_e;

  // One cell state as it enters the block.
  typedef struct packed {
    opcode_e opcode;
    word_t   rho;
    word_t   x;
    word_t   y;
    word_t   z;
    word_t   ep;
    word_t   bx;
    word_t   by;
    word_t   bz;
  } item_t;

  // One lane of the restoring divider.
  typedef struct packed {
    uword_t rem;
    uword_t num;
    uword_t quo;
    logic   ovf;
    logic   neg;
  } div_lane_t;

  // What travels down the divider.
  typedef struct packed {
    item_t                 item;
    logic                  zero_rho;
    uword_t                den;
    div_lane_t [2:0]       lane;
  } div_t;

  // Exact product scaled back by the fraction bits, floored and saturated.
  function automatic word_t fx_round(prod_t p);
    prod_t s;
    s = p >>> FRAC_BITS;
    if (s > prod_t'(WORD_MAX)) begin
      return WORD_MAX;
    end else if (s < prod_t'(WORD_MIN)) begin
      return WORD_MIN;
    end
    return word_t'(s);
  endfunction

  function automatic prod_t fx_prod(word_t a, word_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  function automatic word_t sat_add(word_t a, word_t b);
    logic signed [WORD_BITS:0] s;
    s = $signed({a[WORD_BITS-1], a}) + $signed({b[WORD_BITS-1], b});
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    end
    return word_t'(s[WORD_BITS-1:0]);
  endfunction

  function automatic word_t sat_sub(word_t a, word_t b);
    logic signed [WORD_BITS:0] s;
    s = $signed({a[WORD_BITS-1], a}) - $signed({b[WORD_BITS-1], b});
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    end
    return word_t'(s[WORD_BITS-1:0]);
  endfunction

  // Signed quotient from sign and magnitude, saturated to the word range.
  function automatic word_t sat_from_mag(logic neg, logic ovf, uword_t q);
    if (ovf) begin
      return neg ? WORD_MIN : WORD_MAX;
    end else if (!neg) begin
      return q[WORD_BITS-1] ? WORD_MAX : word_t'(q);
    end
    return (q > SIGN_MAG) ? WORD_MIN : word_t'(~q + uword_t'(1));
  endfunction

endpackage

/* design/mhdcv_prep.sv */
// ----------------------------------------------------------------------------
// MHD state conversion input stage
// Registers the incoming beat and sets up magnitudes for the divider.
// ----------------------------------------------------------------------------
module mhdcv_prep (
  input  logic            clk_i,
  input  logic            en_i,
  input  mhdcv_pkg::item_t item_i,
  output mhdcv_pkg::div_t  div_o
);
  import mhdcv_pkg::*;

  div_t   div_d, div_q;
  uword_t comp [3];
  uword_t ua;
  uword_t r0;

  // Magnitudes, overflow test and the first partial remainder per lane.
  always_comb begin
    comp[0] = item_i.x;
    comp[1] = item_i.y;
    comp[2] = item_i.z;
    div_d.item     = item_i;
    div_d.zero_rho = (item_i.rho == '0);
    div_d.den      = item_i.rho[WORD_BITS-1] ? (~uword_t'(item_i.rho) + uword_t'(1))
                                             : uword_t'(item_i.rho);
    ua = '0;
    r0 = '0;
    for (int i = 0; i < 3; i++) begin
      ua = comp[i][WORD_BITS-1] ? (~comp[i] + uword_t'(1)) : comp[i];
      r0 = ua >> (WORD_BITS - FRAC_BITS);
      div_d.lane[i].neg = comp[i][WORD_BITS-1] ^ item_i.rho[WORD_BITS-1];
      div_d.lane[i].ovf = (r0 >= div_d.den);
      div_d.lane[i].rem = r0;
      div_d.lane[i].num = ua << FRAC_BITS;
      div_d.lane[i].quo = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

/* design/mhdcv_divider.sv */
// ----------------------------------------------------------------------------
// MHD state conversion divider
// Three-lane restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module mhdcv_divider (
  input  logic                          clk_i,
  input  logic [mhdcv_pkg::WORD_BITS-1:0] en_i,
  input  mhdcv_pkg::div_t               div_i,
  output mhdcv_pkg::div_t               div_o
);
  import mhdcv_pkg::*;

  localparam int Steps = WORD_BITS;

  div_t st_q [Steps];

  // One compare and subtract per lane and stage.
  function automatic div_t div_step(div_t d);
    div_t                   r;
    logic [WORD_BITS:0]     rs;
    logic                   bit_q;
    r = d;
    for (int i = 0; i < 3; i++) begin
      rs    = {d.lane[i].rem, d.lane[i].num[WORD_BITS-1]};
      bit_q = (rs >= {1'b0, d.den});
      if (bit_q) begin
        rs = rs - {1'b0, d.den};
      end
      r.lane[i].rem = rs[WORD_BITS-1:0];
      r.lane[i].num = d.lane[i].num << 1;
      r.lane[i].quo = {d.lane[i].quo[WORD_BITS-2:0], bit_q};
    end
    return r;
  endfunction

  for (genvar s = 0; s < Steps; s++) begin : g_stage
    if (s == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en_i[s]) begin
          st_q[s] <= div_step(div_i);
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en_i[s]) begin
          st_q[s] <= div_step(st_q[s-1]);
        end
      end
    end
  end

  assign div_o = st_q[Steps-1];

endmodule

/* design/mhdcv_energy.sv */
// ----------------------------------------------------------------------------
// MHD state conversion energy back end
// Velocities or momenta, kinetic and magnetic energy, pressure or energy.
// ----------------------------------------------------------------------------
module mhdcv_energy (
  input  logic                   clk_i,
  input  logic [8:0]             en_i,
  input  mhdcv_pkg::div_t        div_i,
  input  mhdcv_pkg::coef_t       gamma_m1_i,
  input  mhdcv_pkg::coef_t       inv_gamma_m1_i,
  output mhdcv_pkg::word_t       out_density_o,
  output mhdcv_pkg::word_t       out_x_component_o,
  output mhdcv_pkg::word_t       out_y_component_o,
  output mhdcv_pkg::word_t       out_z_component_o,
  output mhdcv_pkg::word_t       out_pressure_or_energy_o,
  output mhdcv_pkg::word_t       out_field_x_o,
  output mhdcv_pkg::word_t       out_field_y_o,
  output mhdcv_pkg::word_t       out_field_z_o,
  output mhdcv_pkg::status_e     status_o
);
  import mhdcv_pkg::*;

  typedef struct packed {
    item_t         item;
    logic          zero_rho;
    word_t [2:0]   v;
  } s1_t;

  typedef struct packed {
    item_t         item;
    logic          zero_rho;
    word_t [2:0]   v;
    prod_t [2:0]   pv;
    prod_t [2:0]   pb;
    prod_t [2:0]   pm;
    prod_t         pe;
    word_t         half_rho;
  } s2_t;

  typedef struct packed {
    item_t         item;
    logic          zero_rho;
    word_t [2:0]   v;
    word_t [2:0]   sv;
    word_t [2:0]   sb;
    word_t [2:0]   mom;
    word_t         epi;
    word_t         half_rho;
  } s3_t;

  typedef struct packed {
    item_t         item;
    logic          zero_rho;
    word_t [2:0]   v;
    word_t [2:0]   mom;
    word_t         epi;
    word_t         half_rho;
    word_t         ksum;
    word_t         bsum;
  } s4_t;

  typedef struct packed {
    item_t         item;
    logic          zero_rho;
    word_t [2:0]   v;
    word_t [2:0]   mom;
    word_t         epi;
    prod_t         pk;
    word_t         mag;
  } s5_t;

  typedef struct packed {
    item_t         item;
    logic          zero_rho;
    word_t [2:0]   v;
    word_t [2:0]   mom;
    word_t         epi;
    word_t         kin;
    word_t         mag;
  } s6_t;

  typedef struct packed {
    item_t         item;
    logic          zero_rho;
    word_t [2:0]   v;
    word_t [2:0]   mom;
    word_t         t;
  } s7_t;

  typedef struct packed {
    item_t         item;
    logic          zero_rho;
    word_t [2:0]   v;
    word_t [2:0]   mom;
    word_t         t;
    prod_t         pt;
  } s8_t;

  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  s4_t s4_d, s4_q;
  s5_t s5_d, s5_q;
  s6_t s6_d, s6_q;
  s7_t s7_d, s7_q;
  s8_t s8_d, s8_q;

  word_t   rx_d, ry_d, rz_d, rp_d;
  status_e st_d;
  word_t   rho_q, rx_q, ry_q, rz_q, rp_q, bx_q, by_q, bz_q;
  status_e st_q;
  word_t   gm, igm;
  word_t   bvec [3];

  assign gm  = word_t'({1'b0, gamma_m1_i});
  assign igm = word_t'({1'b0, inv_gamma_m1_i});

  // Quotients saturated into velocities, or the input velocities as they are.
  always_comb begin
    s1_d.item     = div_i.item;
    s1_d.zero_rho = div_i.zero_rho;
    for (int i = 0; i < 3; i++) begin
      s1_d.v[i] = sat_from_mag(div_i.lane[i].neg, div_i.lane[i].ovf, div_i.lane[i].quo);
    end
    if (div_i.item.opcode == OP_PRIM_TO_CONS) begin
      s1_d.v[0] = div_i.item.x;
      s1_d.v[1] = div_i.item.y;
      s1_d.v[2] = div_i.item.z;
    end
  end

  // Raw products: squares, momenta and the scaled pressure.
  always_comb begin
    bvec[0] = s1_q.item.bx;
    bvec[1] = s1_q.item.by;
    bvec[2] = s1_q.item.bz;
    s2_d.item     = s1_q.item;
    s2_d.zero_rho = s1_q.zero_rho;
    s2_d.v        = s1_q.v;
    for (int i = 0; i < 3; i++) begin
      s2_d.pv[i] = fx_prod(s1_q.v[i], s1_q.v[i]);
      s2_d.pb[i] = fx_prod(bvec[i], bvec[i]);
      s2_d.pm[i] = fx_prod(s1_q.item.rho, s1_q.v[i]);
    end
    s2_d.pe       = fx_prod(s1_q.item.ep, igm);
    s2_d.half_rho = s1_q.item.rho >>> 1;
  end

  // Products scaled back and saturated.
  always_comb begin
    s3_d.item     = s2_q.item;
    s3_d.zero_rho = s2_q.zero_rho;
    s3_d.v        = s2_q.v;
    s3_d.half_rho = s2_q.half_rho;
    for (int i = 0; i < 3; i++) begin
      s3_d.sv[i]  = fx_round(s2_q.pv[i]);
      s3_d.sb[i]  = fx_round(s2_q.pb[i]);
      s3_d.mom[i] = fx_round(s2_q.pm[i]);
    end
    s3_d.epi = fx_round(s2_q.pe);
  end

  // Sums of squares, left to right.
  always_comb begin
    s4_d.item     = s3_q.item;
    s4_d.zero_rho = s3_q.zero_rho;
    s4_d.v        = s3_q.v;
    s4_d.mom      = s3_q.mom;
    s4_d.epi      = s3_q.epi;
    s4_d.half_rho = s3_q.half_rho;
    s4_d.ksum     = sat_add(sat_add(s3_q.sv[0], s3_q.sv[1]), s3_q.sv[2]);
    s4_d.bsum     = sat_add(sat_add(s3_q.sb[0], s3_q.sb[1]), s3_q.sb[2]);
  end

  // Kinetic product and the halved magnetic sum.
  always_comb begin
    s5_d.item     = s4_q.item;
    s5_d.zero_rho = s4_q.zero_rho;
    s5_d.v        = s4_q.v;
    s5_d.mom      = s4_q.mom;
    s5_d.epi      = s4_q.epi;
    s5_d.pk       = fx_prod(s4_q.half_rho, s4_q.ksum);
    s5_d.mag      = s4_q.bsum >>> 1;
  end

  always_comb begin
    s6_d.item     = s5_q.item;
    s6_d.zero_rho = s5_q.zero_rho;
    s6_d.v        = s5_q.v;
    s6_d.mom      = s5_q.mom;
    s6_d.epi      = s5_q.epi;
    s6_d.kin      = fx_round(s5_q.pk);
    s6_d.mag      = s5_q.mag;
  end

  // Internal energy, or total energy, by direction.
  always_comb begin
    s7_d.item     = s6_q.item;
    s7_d.zero_rho = s6_q.zero_rho;
    s7_d.v        = s6_q.v;
    s7_d.mom      = s6_q.mom;
    if (s6_q.item.opcode == OP_CONS_TO_PRIM) begin
      s7_d.t = sat_sub(sat_sub(s6_q.item.ep, s6_q.kin), s6_q.mag);
    end else begin
      s7_d.t = sat_add(sat_add(s6_q.kin, s6_q.epi), s6_q.mag);
    end
  end

  always_comb begin
    s8_d.item     = s7_q.item;
    s8_d.zero_rho = s7_q.zero_rho;
    s8_d.v        = s7_q.v;
    s8_d.mom      = s7_q.mom;
    s8_d.t        = s7_q.t;
    s8_d.pt       = fx_prod(s7_q.t, gm);
  end

  // Result selection and status.
  always_comb begin
    rx_d = s8_q.mom[0];
    ry_d = s8_q.mom[1];
    rz_d = s8_q.mom[2];
    rp_d = s8_q.t;
    st_d = ST_OK;
    if (s8_q.item.opcode == OP_CONS_TO_PRIM) begin
      if (s8_q.zero_rho) begin
        rx_d = '0;
        ry_d = '0;
        rz_d = '0;
        rp_d = '0;
        st_d = ST_ZERO_DENSITY;
      end else begin
        rx_d = s8_q.v[0];
        ry_d = s8_q.v[1];
        rz_d = s8_q.v[2];
        rp_d = fx_round(s8_q.pt);
        st_d = rp_d[WORD_BITS-1] ? ST_NEG_PRESSURE : ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) s1_q <= s1_d;
    if (en_i[1]) s2_q <= s2_d;
    if (en_i[2]) s3_q <= s3_d;
    if (en_i[3]) s4_q <= s4_d;
    if (en_i[4]) s5_q <= s5_d;
    if (en_i[5]) s6_q <= s6_d;
    if (en_i[6]) s7_q <= s7_d;
    if (en_i[7]) s8_q <= s8_d;
    if (en_i[8]) begin
      rho_q <= s8_q.item.rho;
      rx_q  <= rx_d;
      ry_q  <= ry_d;
      rz_q  <= rz_d;
      rp_q  <= rp_d;
      bx_q  <= s8_q.item.bx;
      by_q  <= s8_q.item.by;
      bz_q  <= s8_q.item.bz;
      st_q  <= st_d;
    end
  end

  assign out_density_o            = rho_q;
  assign out_x_component_o        = rx_q;
  assign out_y_component_o        = ry_q;
  assign out_z_component_o        = rz_q;
  assign out_pressure_or_energy_o = rp_q;
  assign out_field_x_o            = bx_q;
  assign out_field_y_o            = by_q;
  assign out_field_z_o            = bz_q;
  assign status_o                 = st_q;

endmodule

/* design/mhd_state_variable_conversion_core.sv */
// ----------------------------------------------------------------------------
// MHD state variable conversion core
// Converts an ideal-MHD cell state between conserved and primitive form in
// signed Q16.16. The block takes one beat per clock while in_ready_o is high
// and returns one result beat per input beat, in order. There are 42
// register stages: one setup stage, a 32-stage restoring divider that yields
// one quotient bit per stage, and nine stages of multiply, scale, sum and
// select, the last being the output register. Primitive-to-conserved beats
// take the same path and latency. Stalls only close up empty stages, so the
// input keeps accepting while a result waits as long as a bubble remains.
// The two coefficient registers are read directly by the pipeline and are
// to be written only while no beat is in flight.
// ----------------------------------------------------------------------------
module mhd_state_variable_conversion_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              opcode_i,
  input  mhdcv_pkg::word_t                  in_density_i,
  input  mhdcv_pkg::word_t                  in_x_component_i,
  input  mhdcv_pkg::word_t                  in_y_component_i,
  input  mhdcv_pkg::word_t                  in_z_component_i,
  input  mhdcv_pkg::word_t                  in_energy_or_pressure_i,
  input  mhdcv_pkg::word_t                  in_field_x_i,
  input  mhdcv_pkg::word_t                  in_field_y_i,
  input  mhdcv_pkg::word_t                  in_field_z_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output mhdcv_pkg::word_t                  out_density_o,
  output mhdcv_pkg::word_t                  out_x_component_o,
  output mhdcv_pkg::word_t                  out_y_component_o,
  output mhdcv_pkg::word_t                  out_z_component_o,
  output mhdcv_pkg::word_t                  out_pressure_or_energy_o,
  output mhdcv_pkg::word_t                  out_field_x_o,
  output mhdcv_pkg::word_t                  out_field_y_o,
  output mhdcv_pkg::word_t                  out_field_z_o,
  output logic [1:0]                        status_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mhdcv_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  mhdcv_pkg::coef_t                  cfg_data_i
);
  import mhdcv_pkg::*;

  localparam int Stages = 1 + WORD_BITS + 9;

  logic [Stages-1:0] v_q;
  logic [Stages-1:0] en;
  coef_t             gamma_m1_q, inv_gamma_m1_q;
  item_t             item_in;
  div_t              div_prep, div_done;
  status_e           status;

  // A stage loads when it is empty or everything below it can move.
  for (genvar k = 0; k < Stages; k++) begin : g_ready
    assign en[k] = out_ready_i | ~(&v_q[Stages-1:k]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < Stages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[Stages-1];

  // Coefficient registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_m1_q     <= GAMMA_M1_RST;
      inv_gamma_m1_q <= INV_GAMMA_M1_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_GAMMA_M1:     gamma_m1_q     <= cfg_data_i;
        CFG_INV_GAMMA_M1: inv_gamma_m1_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input beat into the pipeline item.
  always_comb begin
    item_in.opcode = opcode_e'(opcode_i);
    item_in.rho    = in_density_i;
    item_in.x      = in_x_component_i;
    item_in.y      = in_y_component_i;
    item_in.z      = in_z_component_i;
    item_in.ep     = in_energy_or_pressure_i;
    item_in.bx     = in_field_x_i;
    item_in.by     = in_field_y_i;
    item_in.bz     = in_field_z_i;
  end

  mhdcv_prep u_prep (
    .clk_i  (clk_i),
    .en_i   (en[0]),
    .item_i (item_in),
    .div_o  (div_prep)
  );

  mhdcv_divider u_divider (
    .clk_i  (clk_i),
    .en_i   (en[WORD_BITS:1]),
    .div_i  (div_prep),
    .div_o  (div_done)
  );

  mhdcv_energy u_energy (
    .clk_i                    (clk_i),
    .en_i                     (en[Stages-1:WORD_BITS+1]),
    .div_i                    (div_done),
    .gamma_m1_i               (gamma_m1_q),
    .inv_gamma_m1_i           (inv_gamma_m1_q),
    .out_density_o            (out_density_o),
    .out_x_component_o        (out_x_component_o),
    .out_y_component_o        (out_y_component_o),
    .out_z_component_o        (out_z_component_o),
    .out_pressure_or_energy_o (out_pressure_or_energy_o),
    .out_field_x_o            (out_field_x_o),
    .out_field_y_o            (out_field_y_o),
    .out_field_z_o            (out_field_z_o),
    .status_o                 (status)
  );

  assign status_o = status;

  // A zero-density result carries zeros in all computed fields.
  a_zero_density: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status == ST_ZERO_DENSITY) |->
      (out_x_component_o == '0 && out_y_component_o == '0 &&
       out_z_component_o == '0 && out_pressure_or_energy_o == '0))
    else $error("zero-density result with non-zero fields");

  // The negative-pressure flag matches the sign of the pressure.
  a_neg_pressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status == ST_NEG_PRESSURE) |-> out_pressure_or_energy_o[WORD_BITS-1])
    else $error("negative-pressure status on a non-negative pressure");

  // A full pipeline with a stalled output takes no new beat.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&v_q && !out_ready_i) |-> !in_ready_o)
    else $error("beat accepted into a full, stalled pipeline");

  // A stalled result stays valid with its pressure or energy held for the next cycle.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_pressure_or_energy_o)))
    else $error("stalled result changed");

endmodule
